### rtl/core/rwr_pkg.sv
// rwr_pkg: shared types and constants of the reorder window receiver
// holds result kinds, field widths and the controller/datapath command and status structs
// no dependencies
`timescale 1ns / 1ps

package rwr_pkg;

    // field widths
    localparam int SEQ_W   = 32;
    localparam int REF_W   = 16;
    localparam int LEN_W   = 16;
    localparam int KIND_W  = 2;
    localparam int WIN_W   = 6;
    localparam int TDATA_W = SEQ_W + REF_W + LEN_W;

    // window size after reset
    localparam logic [WIN_W-1:0] WIN_RESET = 6'd16;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RETX    = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // input transfer taken
        logic out_ack;      // send acknowledge-only result
        logic out_deliver;  // send delivery, advance, start drain of successor
        logic drain_load;   // take drained descriptor from the store
        logic store;        // store attempt and scan setup
        logic scan_step;    // one gap scan position
        logic flush;        // send held retransmit request as final result
    } rwr_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_ack;
        logic is_deliver;
        logic next_stored;
        logic scan_done;
        logic scan_hit;
        logic hold_valid;
        logic out_free;
    } rwr_status_t;

endpackage

### rtl/core/reorder_window_receiver_unit.sv
// reorder_window_receiver_unit: top level of the selective repeat receive window
// depends on rwr_pkg; instantiates rwr_ctrl and rwr_datapath (which holds rwr_ram)
//
// Usage:
//   s_ channel carries one data packet descriptor per transfer (sequence number,
//   payload reference, length). m_ channel carries results: deliveries, plain
//   acknowledges and retransmit requests, kind in m_tuser, m_tlast on the final
//   result of each input packet. A packet inside the window that fills no gap
//   may produce no result at all.
//   cfg_wr_en/cfg_wr_data write the window size, only while the block is idle.
// Processing steps:
//   acknowledge-only packet: taken in idle, classified, then the result is
//   registered; the next packet is taken only after the return to idle.
//   in-order packet: taken and classified, then delivered, plus a drain step
//   (descriptor store read) and a further delivery per stored successor.
//   out-of-order packet: classified, stored, one gap scan step per window position,
//   a step to close the scan, one to send the held final request; the scan runs
//   one slot a cycle over the effective window unless a request waits on the output.
// Reset: window size 16, delivered sequence and retry mark zero, store empty.
// Stall: the output register holds its result while m_tready is low; the
//   sequencer waits while it has a further result to send and the register is full.
`timescale 1ns / 1ps

module reorder_window_receiver_unit
    import rwr_pkg::*;
#(
    parameter int WINDOW_MAX = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [WIN_W-1:0]   cfg_wr_data,   // window_size
    // input packets
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,       // seq[31:0], payload_ref[47:32], length[63:48]
    // results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,       // out_seq[31:0], out_payload_ref[47:32],
                                              // out_length[63:48]
    output logic [KIND_W-1:0]  m_tuser,       // kind[1:0]
    output logic               m_tlast
);

    rwr_cmd_t          cmd;
    rwr_status_t       st;
    logic [SEQ_W-1:0]  out_seq;
    logic [REF_W-1:0]  out_ref;
    logic [LEN_W-1:0]  out_len;

    // sequencer
    rwr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath and store
    rwr_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_seq      (s_tdata[SEQ_W-1:0]),
        .in_ref      (s_tdata[SEQ_W+REF_W-1:SEQ_W]),
        .in_len      (s_tdata[TDATA_W-1:SEQ_W+REF_W]),
        .cmd         (cmd),
        .st          (st),
        .m_tready    (m_tready),
        .m_valid     (m_tvalid),
        .m_kind      (m_tuser),
        .m_seq       (out_seq),
        .m_ref       (out_ref),
        .m_len       (out_len),
        .m_last      (m_tlast)
    );

    // result packing
    assign m_tdata = {out_len, out_ref, out_seq};

endmodule

### rtl/core/rwr_ram.sv
// rwr_ram: generic single write port, single read port ram with registered read
// used for the reorder store descriptors; no package dependency
`timescale 1ns / 1ps

module rwr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/rwr_datapath.sv
// rwr_datapath: sequence state, slot valid flags, descriptor store, gap scan and output register
// depends on rwr_pkg and rwr_ram; driven by rwr_ctrl through rwr_cmd_t
`timescale 1ns / 1ps

module rwr_datapath
    import rwr_pkg::*;
#(
    parameter int WINDOW_MAX = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [WIN_W-1:0]   cfg_wr_data,
    input  logic [SEQ_W-1:0]   in_seq,
    input  logic [REF_W-1:0]   in_ref,
    input  logic [LEN_W-1:0]   in_len,
    input  rwr_cmd_t           cmd,
    output rwr_status_t        st,
    input  logic               m_tready,
    output logic               m_valid,
    output logic [KIND_W-1:0]  m_kind,
    output logic [SEQ_W-1:0]   m_seq,
    output logic [REF_W-1:0]   m_ref,
    output logic [LEN_W-1:0]   m_len,
    output logic               m_last
);

    localparam int SW   = $clog2(WINDOW_MAX);      // slot index bits
    localparam int SUMW = SW + 1;                  // slot sum before wrap
    localparam int CW   = $clog2(WINDOW_MAX + 1);  // count and window bits

    // slot index plus one, wrapping at the store depth
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        if (s == SW'(WINDOW_MAX - 1)) begin
            r = '0;
        end else begin
            r = s + SW'(1);
        end
        return r;
    endfunction

    // configuration and sequence state
    logic [WIN_W-1:0]      win_reg;
    logic [SEQ_W-1:0]      delivered_reg;
    logic [SW-1:0]         base_reg;       // delivered sequence modulo store depth
    logic [SEQ_W-1:0]      retry_reg;
    logic [CW-1:0]         count_reg;
    logic [WINDOW_MAX-1:0] valid_reg;

    // current item
    logic [SEQ_W-1:0]      seq_reg;
    logic [SEQ_W-1:0]      dist_reg;
    logic [REF_W-1:0]      cur_ref_reg;
    logic [LEN_W-1:0]      cur_len_reg;

    // gap scan
    logic [SEQ_W-1:0]      t_reg;
    logic [SW-1:0]         tslot_reg;
    logic [CW-1:0]         i_reg;
    logic [SEQ_W-1:0]      hold_reg;
    logic                  hold_valid_reg;

    // output register
    logic                  m_valid_reg;
    logic [KIND_W-1:0]     m_kind_reg;
    logic [SEQ_W-1:0]      m_seq_reg;
    logic [REF_W-1:0]      m_ref_reg;
    logic [LEN_W-1:0]      m_len_reg;
    logic                  m_last_reg;

    logic                  out_load;
    logic [KIND_W-1:0]     m_kind_next;
    logic [SEQ_W-1:0]      m_seq_next;
    logic [REF_W-1:0]      m_ref_next;
    logic [LEN_W-1:0]      m_len_next;
    logic                  m_last_next;

    logic [CW-1:0]         w_eff;
    logic [SEQ_W-1:0]      w32;
    logic [SW-1:0]         nslot;
    logic [SW-1:0]         nnslot;
    logic [SUMW-1:0]       k_sum;
    logic [SW-1:0]         k_slot;
    logic                  store_ok;
    logic [SEQ_W-1:0]      span_seq;
    logic [SEQ_W-1:0]      span_retry;
    logic                  scan_hit;
    logic                  next_stored;
    logic                  out_free;
    logic [REF_W+LEN_W-1:0] rd_desc;

    // effective window, clipped to the store depth
    always_comb begin
        if (win_reg > WIN_W'(WINDOW_MAX)) begin
            w_eff = CW'(WINDOW_MAX);
        end else begin
            w_eff = CW'(win_reg);
        end
    end
    assign w32 = SEQ_W'(w_eff);

    // slot arithmetic relative to the delivered sequence
    assign nslot  = slot_inc(base_reg);
    assign nnslot = slot_inc(nslot);
    assign k_sum  = SUMW'(base_reg) + dist_reg[SUMW-1:0];
    assign k_slot = (k_sum >= SUMW'(WINDOW_MAX)) ? SW'(k_sum - SUMW'(WINDOW_MAX)) : SW'(k_sum);

    // stored entries always lie within the store depth ahead of the delivered
    // sequence, so a set valid flag at the mapped slot implies a matching tag
    assign next_stored = valid_reg[nnslot];
    assign store_ok    = !valid_reg[k_slot] && (count_reg < w_eff);

    // gap scan test for the current position
    assign span_seq   = seq_reg - t_reg;
    assign span_retry = retry_reg - t_reg;
    assign scan_hit   = !valid_reg[tslot_reg] && (span_seq <= w32) && (span_retry > w32);

    assign out_free = !m_valid_reg || m_tready;

    // status to the controller; the next packet in order is delivered whatever the window
    always_comb begin
        st.is_ack      = (dist_reg == '0) || ((dist_reg > w32) && (dist_reg != SEQ_W'(1)));
        st.is_deliver  = (dist_reg == SEQ_W'(1));
        st.next_stored = next_stored;
        st.scan_done   = (i_reg == w_eff);
        st.scan_hit    = scan_hit;
        st.hold_valid  = hold_valid_reg;
        st.out_free    = out_free;
    end

    // result selection
    always_comb begin
        out_load    = 1'b0;
        m_kind_next = KIND_RETX;
        m_seq_next  = hold_reg;
        m_ref_next  = '0;
        m_len_next  = '0;
        m_last_next = 1'b0;
        if (cmd.out_ack) begin
            out_load    = 1'b1;
            m_kind_next = KIND_ACK;
            m_seq_next  = seq_reg;
            m_last_next = 1'b1;
        end else if (cmd.out_deliver) begin
            out_load    = 1'b1;
            m_kind_next = KIND_DELIVER;
            m_seq_next  = delivered_reg + SEQ_W'(1);
            m_ref_next  = cur_ref_reg;
            m_len_next  = cur_len_reg;
            m_last_next = !next_stored;
        end else if (cmd.scan_step && scan_hit && hold_valid_reg) begin
            out_load    = 1'b1;
        end else if (cmd.flush) begin
            out_load    = 1'b1;
            m_last_next = 1'b1;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_RESET;
        end else if (cfg_wr_en) begin
            win_reg <= cfg_wr_data;
        end
    end

    // sequence state, store flags and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delivered_reg  <= '0;
            base_reg       <= '0;
            retry_reg      <= '0;
            count_reg      <= '0;
            valid_reg      <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_deliver) begin
                delivered_reg <= delivered_reg + SEQ_W'(1);
                base_reg      <= nslot;
                if (next_stored) begin
                    valid_reg[nnslot] <= 1'b0;
                    if (count_reg != '0) begin
                        count_reg <= count_reg - CW'(1);
                    end
                end
            end
            if (cmd.store) begin
                hold_valid_reg <= 1'b0;
                if (store_ok) begin
                    valid_reg[k_slot] <= 1'b1;
                    count_reg         <= count_reg + CW'(1);
                end
            end
            if (cmd.scan_step && scan_hit) begin
                hold_valid_reg <= 1'b1;
                retry_reg      <= t_reg;
            end
            if (cmd.flush) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    // item capture, drain descriptor and scan position
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            seq_reg     <= in_seq;
            dist_reg    <= in_seq - delivered_reg;
            cur_ref_reg <= in_ref;
            cur_len_reg <= in_len;
        end
        if (cmd.drain_load) begin
            cur_ref_reg <= rd_desc[REF_W+LEN_W-1:LEN_W];
            cur_len_reg <= rd_desc[LEN_W-1:0];
        end
        if (cmd.store) begin
            t_reg     <= delivered_reg + SEQ_W'(1);
            tslot_reg <= nslot;
            i_reg     <= '0;
        end
        if (cmd.scan_step) begin
            t_reg     <= t_reg + SEQ_W'(1);
            tslot_reg <= slot_inc(tslot_reg);
            i_reg     <= i_reg + CW'(1);
            if (scan_hit) begin
                hold_reg <= t_reg;
            end
        end
    end

    // descriptor store
    rwr_ram #(
        .WIDTH (REF_W + LEN_W),
        .DEPTH (WINDOW_MAX)
    ) u_desc_ram (
        .aclk    (aclk),
        .wr_en   (cmd.store && store_ok),
        .wr_addr (k_slot),
        .wr_data ({cur_ref_reg, cur_len_reg}),
        .rd_en   (cmd.out_deliver && next_stored),
        .rd_addr (nnslot),
        .rd_data (rd_desc)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind_reg <= m_kind_next;
            m_seq_reg  <= m_seq_next;
            m_ref_reg  <= m_ref_next;
            m_len_reg  <= m_len_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_seq   = m_seq_reg;
    assign m_ref   = m_ref_reg;
    assign m_len   = m_len_reg;
    assign m_last  = m_last_reg;

    // stored count tracks the valid flags
    a_count_matches_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CW'($countones(valid_reg)))
        else $error("stored count differs from number of valid slots");

    // only deliveries carry a descriptor
    a_no_desc_on_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg != KIND_DELIVER) |-> (m_ref_reg == '0 && m_len_reg == '0))
        else $error("descriptor on non-delivery result");

    // a result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register loaded while stalled");

endmodule

### rtl/core/rwr_ctrl.sv
// rwr_ctrl: item sequencer of the reorder window receiver
// depends on rwr_pkg; issues rwr_cmd_t to rwr_datapath and reads rwr_status_t back
`timescale 1ns / 1ps

module rwr_ctrl
    import rwr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  rwr_status_t st,
    output rwr_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CLASSIFY = 3'd1;
    localparam logic [2:0] ST_ACK      = 3'd2;
    localparam logic [2:0] ST_DELIVER  = 3'd3;
    localparam logic [2:0] ST_DRAIN    = 3'd4;
    localparam logic [2:0] ST_STORE    = 3'd5;
    localparam logic [2:0] ST_SCAN     = 3'd6;
    localparam logic [2:0] ST_FLUSH    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (st.is_ack) begin
                    state_next = ST_ACK;
                end else if (st.is_deliver) begin
                    state_next = ST_DELIVER;
                end else begin
                    state_next = ST_STORE;
                end
            end
            ST_ACK: begin
                if (st.out_free) begin
                    cmd.out_ack = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_DELIVER: begin
                if (st.out_free) begin
                    cmd.out_deliver = 1'b1;
                    state_next      = st.next_stored ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN: begin
                cmd.drain_load = 1'b1;
                state_next     = ST_DELIVER;
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (st.scan_done) begin
                    state_next = ST_FLUSH;
                end else if (!(st.scan_hit && st.hold_valid && !st.out_free)) begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!st.hold_valid) begin
                    state_next = ST_IDLE;
                end else if (st.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a drain always follows a delivery that found a stored successor
    a_drain_after_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> ($past(cmd.out_deliver) && $past(st.next_stored)))
        else $error("drain without preceding delivery");

    // a transfer is only taken while idle; each one starts classification
    a_capture_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_CLASSIFY))
        else $error("capture did not start classification");

    // input ready only while idle
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");

endmodule

### verif/tb.sv
// tb: self-checking testbench for reorder_window_receiver_unit
// mirrors the receive window in a local predictor and checks every result transfer
// depends on rwr_pkg and the rtl of reorder_window_receiver_unit
`timescale 1ns / 1ps

module tb;
    import rwr_pkg::*;

    localparam int SLOT_COUNT   = 32;
    localparam int SETTLE_CYCLE = 80;
    localparam int TAIL_CYCLE   = 80;
    localparam int LIMIT_CYCLE  = 400000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic [REF_W-1:0]  pay_ref;
        logic [LEN_W-1:0]  pay_len;
        logic              last;
    } rx_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [WIN_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]  m_tuser;
    logic               m_tlast;

    // predictor state of the receive window
    logic [WIN_W-1:0] win_reg;
    logic [SEQ_W-1:0] dlv_seq;
    logic [SEQ_W-1:0] retry_seq;
    int unsigned      store_cnt;
    logic             slot_used [SLOT_COUNT];
    logic [SEQ_W-1:0] slot_tag  [SLOT_COUNT];
    logic [31:0]      slot_desc [SLOT_COUNT];

    rx_result_t expected_results [$];
    rx_result_t held_result;
    logic       held_valid;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int packets_sent  = 0;
    int results_seen  = 0;
    int kind_seen [3] = '{0, 0, 0};
    int cycle_count   = 0;

    reorder_window_receiver_unit #(
        .WINDOW_MAX (SLOT_COUNT)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLE) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("reorder_window_receiver_unit: mismatch");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic int unsigned eff_window();
        return (win_reg > SLOT_COUNT) ? SLOT_COUNT : win_reg;
    endfunction

    function automatic logic in_store(input logic [SEQ_W-1:0] s);
        int k = s % SLOT_COUNT;
        return slot_used[k] && (slot_tag[k] == s);
    endfunction

    function automatic void clear_window_state();
        win_reg   = WIN_RESET;
        dlv_seq   = '0;
        retry_seq = '0;
        store_cnt = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_used[i] = 1'b0;
            slot_tag[i]  = '0;
            slot_desc[i] = '0;
        end
    endfunction

    // results are held back by one so the final one of a packet can carry last
    function automatic void queue_result(input logic [KIND_W-1:0] kind,
                                         input logic [SEQ_W-1:0] sq,
                                         input logic [REF_W-1:0] pr,
                                         input logic [LEN_W-1:0] pl);
        if (held_valid)
            expected_results.push_back(held_result);
        held_result.kind    = kind;
        held_result.seq     = sq;
        held_result.pay_ref = pr;
        held_result.pay_len = pl;
        held_result.last    = 1'b0;
        held_valid = 1'b1;
    endfunction

    // expected results of one packet transfer, state updated in place
    function automatic void predict_receive_step(input logic [SEQ_W-1:0] sq,
                                                 input logic [REF_W-1:0] pr,
                                                 input logic [LEN_W-1:0] pl);
        int unsigned      w;
        logic [SEQ_W-1:0] seq_dist;
        logic [SEQ_W-1:0] cur;
        logic [SEQ_W-1:0] nxt;
        logic [SEQ_W-1:0] t;
        logic [SEQ_W-1:0] span_seq;
        logic [SEQ_W-1:0] span_retry;
        logic [REF_W-1:0] r;
        logic [LEN_W-1:0] l;
        logic             done;
        int               k;

        w        = eff_window();
        seq_dist = sq - dlv_seq;
        held_valid = 1'b0;
        if (seq_dist > w || seq_dist <= 1) begin
            if (seq_dist == 1) begin
                // deliver, then drain stored successors in order
                cur  = sq;
                r    = pr;
                l    = pl;
                done = 1'b0;
                while (!done) begin
                    queue_result(KIND_DELIVER, cur, r, l);
                    dlv_seq = cur;
                    nxt = cur + 1;
                    if (!in_store(nxt)) begin
                        done = 1'b1;
                    end else begin
                        k = nxt % SLOT_COUNT;
                        slot_used[k] = 1'b0;
                        r = slot_desc[k][31:16];
                        l = slot_desc[k][15:0];
                        if (store_cnt > 0)
                            store_cnt--;
                        cur = nxt;
                    end
                end
            end else begin
                queue_result(KIND_ACK, sq, '0, '0);
            end
        end else begin
            // store attempt, then gap scan over the window
            k = sq % SLOT_COUNT;
            if (!slot_used[k] && store_cnt < w) begin
                slot_used[k] = 1'b1;
                slot_tag[k]  = sq;
                slot_desc[k] = {pr, pl};
                store_cnt++;
            end
            for (int i = 0; i < w; i++) begin
                t = dlv_seq + 1 + i;
                if (!in_store(t)) begin
                    span_seq   = sq - t;
                    span_retry = retry_seq - t;
                    if (span_seq <= w && span_retry > w) begin
                        queue_result(KIND_RETX, t, '0, '0);
                        retry_seq = t;
                    end
                end
            end
        end
        if (held_valid) begin
            held_result.last = 1'b1;
            expected_results.push_back(held_result);
        end
    endfunction

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("error at cycle %0d: %s", cycle_count, msg);
    endtask

    // result checker
    always @(posedge aclk) begin : result_check
        rx_result_t want;
        rx_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind    = m_tuser;
            got.seq     = m_tdata[31:0];
            got.pay_ref = m_tdata[47:32];
            got.pay_len = m_tdata[63:48];
            got.last    = m_tlast;
            results_seen++;
            if (got.kind <= KIND_RETX)
                kind_seen[got.kind]++;
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result kind %0d seq %08h ref %04h len %04h last %0b",
                              got.kind, got.seq, got.pay_ref, got.pay_len, got.last));
            end else begin
                want = expected_results.pop_front();
                if (got.kind != want.kind || got.seq != want.seq ||
                    got.pay_ref != want.pay_ref || got.pay_len != want.pay_len ||
                    got.last != want.last)
                    note_mismatch($sformatf({"expected kind %0d seq %08h ref %04h len %04h last %0b,",
                                  " got kind %0d seq %08h ref %04h len %04h last %0b"},
                                  want.kind, want.seq, want.pay_ref, want.pay_len, want.last,
                                  got.kind, got.seq, got.pay_ref, got.pay_len, got.last));
            end
        end
    end

    // one packet transfer; tvalid is left high for a following call to keep or drop
    task automatic send_packet(input logic [SEQ_W-1:0] sq,
                               input logic [REF_W-1:0] pr,
                               input logic [LEN_W-1:0] pl);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pl, pr, sq};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_receive_step(sq, pr, pl);
        packets_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        // an out-of-order packet may still be scanning without a result
        repeat (SETTLE_CYCLE) @(posedge aclk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_reg = value;
    endtask

    // reset window: in order, duplicates, far and behind, gaps and drain
    task automatic test_reset_window_order();
        send_packet(32'd1, 16'hFFFF, 16'hFFFF);
        send_packet(32'd1, 16'h1234, 16'h5678);
        send_packet(32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        send_packet(32'd4, 16'h0000, 16'h0000);
        send_packet(32'd4, 16'hA5A5, 16'h5A5A);
        send_packet(32'd3, 16'h0003, 16'h0300);
        send_packet(32'd2, 16'h0002, 16'h0200);
        send_packet(32'd21, 16'h0021, 16'h2100);
        send_packet(32'd20, 16'h0020, 16'h2000);
    endtask

    // zero window stores nothing; oversize window is capped at the store size
    task automatic test_window_extremes();
        set_window(6'd0);
        send_packet(dlv_seq + 1, 16'hBEEF, 16'h0001);
        send_packet(dlv_seq + 2, 16'hCAFE, 16'h0002);
        set_window(6'd63);
        send_packet(dlv_seq + 33, 16'h0101, 16'h0033);
        send_packet(dlv_seq + 32, 16'h0202, 16'h0032);
    endtask

    // single-packet window, where only the next packet is taken, then a window of two that stores a packet
    task automatic test_store_full();
        set_window(6'd1);
        send_packet(dlv_seq + 2, 16'h0303, 16'h0002);
        send_packet(dlv_seq + 1, 16'h0404, 16'h0001);
        set_window(6'd2);
        send_packet(dlv_seq + 2, 16'h0505, 16'h0002);
    endtask

    task automatic send_noise();
        int unsigned w;
        logic [SEQ_W-1:0] sq;
        w = eff_window();
        case ($urandom_range(0, 3))
            0: sq = $urandom();
            1: sq = dlv_seq;
            2: sq = dlv_seq + w + $urandom_range(1, 8);
            default: sq = dlv_seq - $urandom_range(1, 100);
        endcase
        send_packet(sq, $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    // bursts from the next expected sequence, sometimes shuffled, with drops, repeats and noise packets
    task automatic test_random_traffic(input int s_pct, input int r_pct,
                                       input logic [WIN_W-1:0] win, input int n_items);
        logic [SEQ_W-1:0] burst [0:39];
        logic [SEQ_W-1:0] swap_seq;
        int               sent;
        int               k;
        int               m;
        logic [REF_W-1:0] pr;
        logic [LEN_W-1:0] pl;

        set_window(win);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 20) begin
                send_noise();
                sent++;
            end else begin
                k = $urandom_range(1, eff_window() + 2);
                for (int j = 0; j < k; j++)
                    burst[j] = dlv_seq + 1 + j;
                if ($urandom_range(0, 1) == 1) begin
                    for (int j = k - 1; j > 0; j--) begin
                        m = $urandom_range(0, j);
                        swap_seq = burst[j];
                        burst[j] = burst[m];
                        burst[m] = swap_seq;
                    end
                end
                for (int j = 0; j < k; j++) begin
                    if ($urandom_range(0, 99) >= 10) begin
                        pr = $urandom_range(0, 65535);
                        pl = $urandom_range(0, 65535);
                        send_packet(burst[j], pr, pl);
                        sent++;
                        if ($urandom_range(0, 99) < 5) begin
                            send_packet(burst[j], pr, pl);
                            sent++;
                        end
                    end
                end
            end
        end
    endtask

    // test sequence
    initial begin
        clear_window_state();
        held_valid = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 17;
        recv_idle_pct = 82;
        test_reset_window_order();
        test_window_extremes();
        test_store_full();
        test_random_traffic(17, 82, 6'd32, 48);
        test_random_traffic(82, 17, 6'd3, 48);
        test_random_traffic(0, 0, 6'd20, 48);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLE) @(posedge aclk);

        $display("covered %0d packet transfers and %0d result transfers", packets_sent,
                 results_seen);
        $display("%0d deliveries, %0d acknowledges, %0d retransmit requests; windows 0 to 63",
                 kind_seen[KIND_DELIVER], kind_seen[KIND_ACK], kind_seen[KIND_RETX]);
        if (fail_count == 0) begin
            $display("reorder_window_receiver_unit: match");
        end else begin
            $display("%0d errors", fail_count);
            $display("reorder_window_receiver_unit: mismatch");
        end
        $finish;
    end

endmodule
